// ===== hw/rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers, compiled out for synthesis.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
	`ASSERT_ALWAYS(lbl, clk, rstn, !(cond), msg)
`else
`define ASSERT_ALWAYS(lbl, clk, rstn, prop, msg)
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`endif
`endif

// ===== hw/rtl/cpip_pkg.sv =====
// ---------------------------------------------------------------------------
// cpip_pkg
// Shared types and constants of the centroid point-in-polygon unit.
// ---------------------------------------------------------------------------
package cpip_pkg;

	localparam int COORD_W = 31;              // vertex and centroid coordinates
	localparam int DIFF_W  = COORD_W + 1;     // coordinate differences
	localparam int PROD_W  = 2 * DIFF_W;      // edge cross products
	localparam int TDATA_W = 64;

	localparam logic OP_SUBJECT  = 1'b0;
	localparam logic OP_BOUNDARY = 1'b1;

	localparam logic KIND_CENTROID = 1'b0;
	localparam logic KIND_VERDICT  = 1'b1;

	typedef struct packed {
		logic accept;      // input request taken this cycle
		logic load_close;  // load closing edge (last -> first)
		logic diff;        // register edge differences
		logic mul_lhs;     // multiplier pass 1
		logic mul_rhs;     // multiplier pass 2
		logic cmp;         // compare products, update parity
		logic div_start;   // start centroid division
		logic emit;        // load output register
		logic emit_kind;
	} cmd_t;

	typedef struct packed {
		logic starting;    // next vertex opens a new polygon
		logic div_busy;
		logic div_done;
		logic out_free;    // output register can take a result
	} sts_t;

endpackage

// ===== hw/rtl/cpip_div.sv =====
// ---------------------------------------------------------------------------
// cpip_div
// Restoring divider, one quotient bit per cycle: signed sum by vertex count,
// truncating toward zero.
// ---------------------------------------------------------------------------
module cpip_div #(
	parameter int SUM_W = 44,
	parameter int CNT_W = 13
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic signed [SUM_W-1:0]      sum,
	input  logic        [CNT_W-1:0]      count,
	output logic                         busy,
	output logic                         done,
	output logic signed [cpip_pkg::COORD_W-1:0] quo
);

	localparam int STEP_W = $clog2(SUM_W);

	logic              busy_q;
	logic              done_q;
	logic              neg_q;
	logic [STEP_W-1:0] step_q;
	logic [SUM_W-1:0]  dvd_q;
	logic [CNT_W-1:0]  den_q;
	logic [CNT_W-1:0]  rem_q;
	logic [CNT_W:0]    trial;
	logic [CNT_W:0]    trial_sub;
	logic              bit_ok;
	logic [SUM_W-1:0]  quo_full;

	assign trial     = {rem_q, dvd_q[SUM_W-1]};
	assign trial_sub = trial - {1'b0, den_q};
	assign bit_ok    = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == STEP_W'(SUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= sum[SUM_W-1];
			dvd_q <= sum[SUM_W-1] ? (~sum + 1'b1) : sum;
			den_q <= count;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= bit_ok ? trial_sub[CNT_W-1:0] : trial[CNT_W-1:0];
			dvd_q <= {dvd_q[SUM_W-2:0], bit_ok};
		end
	end

	assign quo_full = neg_q ? (~dvd_q + 1'b1) : dvd_q;
	assign quo      = quo_full[cpip_pkg::COORD_W-1:0];
	assign busy     = busy_q;
	assign done     = done_q;

endmodule

// ===== hw/rtl/cpip_dp.sv =====
// ---------------------------------------------------------------------------
// cpip_dp
// Datapath: vertex sums, centroid dividers, edge registers, shared
// multiplier, crossing parity and the output register.
// ---------------------------------------------------------------------------
module cpip_dp #(
	parameter int MAX_VERTICES = 4096
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  cpip_pkg::cmd_t                       cmd,
	output cpip_pkg::sts_t                       sts,
	input  logic [cpip_pkg::TDATA_W-1:0]         s_tdata,
	input  logic                                 s_tuser,
	input  logic                                 s_tlast,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [cpip_pkg::TDATA_W-1:0]         m_tdata,
	output logic                                 m_tuser
);

	localparam int CW     = cpip_pkg::COORD_W;
	localparam int DW     = cpip_pkg::DIFF_W;
	localparam int PW     = cpip_pkg::PROD_W;
	localparam int CNT_W  = $clog2(MAX_VERTICES + 1);
	localparam int SUM_W  = CW + CNT_W;

	logic signed [CW-1:0] in_x, in_y;
	assign in_x = s_tdata[CW-1:0];
	assign in_y = s_tdata[2*CW-1:CW];

	logic                    mid_q;
	logic signed [SUM_W-1:0] sum_x_q, sum_y_q;
	logic        [CNT_W-1:0] count_q;
	logic signed [CW-1:0]    cen_x_q, cen_y_q;
	logic signed [CW-1:0]    first_x_q, first_y_q, prev_x_q, prev_y_q;
	logic signed [CW-1:0]    ax_q, ay_q, bx_q, by_q;
	logic                    parity_q;

	logic                    starting;
	logic signed [SUM_W-1:0] sum_x_base, sum_y_base;
	logic        [CNT_W-1:0] count_base;

	assign starting   = !mid_q;
	assign sum_x_base = starting ? '0 : sum_x_q;
	assign sum_y_base = starting ? '0 : sum_y_q;
	assign count_base = starting ? '0 : count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mid_q   <= 1'b0;
			count_q <= '0;
		end else if (cmd.accept) begin
			mid_q <= !s_tlast;
			if (s_tuser == cpip_pkg::OP_SUBJECT && count_base < CNT_W'(MAX_VERTICES))
				count_q <= count_base + 1'b1;
			else
				count_q <= count_base;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			if (s_tuser == cpip_pkg::OP_SUBJECT && count_base < CNT_W'(MAX_VERTICES)) begin
				sum_x_q <= sum_x_base + SUM_W'(in_x);
				sum_y_q <= sum_y_base + SUM_W'(in_y);
			end else begin
				sum_x_q <= sum_x_base;
				sum_y_q <= sum_y_base;
			end
			if (starting) begin
				first_x_q <= in_x;
				first_y_q <= in_y;
				prev_x_q  <= in_x;
				prev_y_q  <= in_y;
			end else if (s_tuser == cpip_pkg::OP_BOUNDARY) begin
				// edge from previous boundary vertex to this one
				ax_q     <= prev_x_q;
				ay_q     <= prev_y_q;
				bx_q     <= in_x;
				by_q     <= in_y;
				prev_x_q <= in_x;
				prev_y_q <= in_y;
			end
		end else if (cmd.load_close) begin
			ax_q <= prev_x_q;
			ay_q <= prev_y_q;
			bx_q <= first_x_q;
			by_q <= first_y_q;
		end
	end

	// centroid dividers, both lanes in lockstep
	logic                 div_busy_x, div_busy_y, div_done_x, div_done_y;
	logic signed [CW-1:0] quo_x, quo_y;

	cpip_div #(.SUM_W(SUM_W), .CNT_W(CNT_W)) u_div_x (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.sum    (sum_x_q),
		.count  (count_q),
		.busy   (div_busy_x),
		.done   (div_done_x),
		.quo    (quo_x)
	);

	cpip_div #(.SUM_W(SUM_W), .CNT_W(CNT_W)) u_div_y (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.sum    (sum_y_q),
		.count  (count_q),
		.busy   (div_busy_y),
		.done   (div_done_y),
		.quo    (quo_y)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cen_x_q <= '0;
			cen_y_q <= '0;
		end else if (div_done_x && div_done_y) begin
			cen_x_q <= quo_x;
			cen_y_q <= quo_y;
		end
	end

	// edge test: differences, two multiplier passes, compare
	logic signed [DW-1:0] dca_s1, dba_s1, dyc_s1, d_s1;
	logic                 cross_s1, dpos_s1;
	logic signed [DW-1:0] d_next;
	logic signed [DW-1:0] mul_a, mul_b;
	logic signed [PW-1:0] prod;
	logic signed [PW-1:0] lhs_s2, rhs_s2;
	logic                 left;

	assign d_next = DW'(by_q) - DW'(ay_q);

	always_ff @(posedge clk) begin
		if (cmd.diff) begin
			dca_s1   <= DW'(cen_x_q) - DW'(ax_q);
			dba_s1   <= DW'(bx_q) - DW'(ax_q);
			dyc_s1   <= DW'(cen_y_q) - DW'(ay_q);
			d_s1     <= d_next;
			cross_s1 <= (ay_q > cen_y_q) != (by_q > cen_y_q);
			dpos_s1  <= d_next > 0;
		end
	end

	assign mul_a = cmd.mul_rhs ? dba_s1 : dca_s1;
	assign mul_b = cmd.mul_rhs ? dyc_s1 : d_s1;
	assign prod  = PW'(mul_a) * PW'(mul_b);

	always_ff @(posedge clk) begin
		if (cmd.mul_lhs)
			lhs_s2 <= prod;
		if (cmd.mul_rhs)
			rhs_s2 <= prod;
	end

	assign left = dpos_s1 ? (lhs_s2 < rhs_s2) : (lhs_s2 > rhs_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			parity_q <= 1'b0;
		end else if (cmd.accept && starting) begin
			parity_q <= 1'b0;
		end else if (cmd.cmp && cross_s1 && left) begin
			parity_q <= !parity_q;
		end
	end

	// output register
	logic                 out_valid_q;
	logic                 out_kind_q;
	logic                 out_inside_q;
	logic signed [CW-1:0] out_x_q, out_y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_kind_q   <= cmd.emit_kind;
			out_inside_q <= (cmd.emit_kind == cpip_pkg::KIND_VERDICT) && parity_q;
			out_x_q      <= cen_x_q;
			out_y_q      <= cen_y_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_kind_q;
	assign m_tdata  = {{(cpip_pkg::TDATA_W - 2*CW - 1){1'b0}}, out_y_q, out_x_q, out_inside_q};

	assign sts.starting = starting;
	assign sts.div_busy = div_busy_x || div_busy_y;
	assign sts.div_done = div_done_x && div_done_y;
	assign sts.out_free = !out_valid_q || m_tready;

endmodule

// ===== hw/rtl/cpip_ctrl.sv =====
// ---------------------------------------------------------------------------
// cpip_ctrl
// Controller: sequences input acceptance, edge tests, centroid division
// and result emission.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module cpip_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_tvalid,
	input  logic           s_tuser,
	input  logic           s_tlast,
	output logic           s_tready,
	input  cpip_pkg::sts_t sts,
	output cpip_pkg::cmd_t cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_E_DIFF,
		ST_E_LHS,
		ST_E_RHS,
		ST_E_CMP,
		ST_DIV_GO,
		ST_DIV_WAIT,
		ST_EMIT
	} state_t;

	state_t state_q;
	logic   kind_q;
	logic   close_q;   // closing edge still to test
	logic   done_q;    // a result is due for this request
	logic   accept;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			kind_q  <= cpip_pkg::KIND_CENTROID;
			close_q <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						kind_q  <= s_tuser;
						done_q  <= s_tlast;
						close_q <= (s_tuser == cpip_pkg::OP_BOUNDARY) && s_tlast && !sts.starting;
						if (s_tuser == cpip_pkg::OP_SUBJECT)
							state_q <= s_tlast ? ST_DIV_GO : ST_IDLE;
						else if (!sts.starting)
							state_q <= ST_E_DIFF;
						else
							// first boundary vertex: no edge yet; a single-vertex boundary is degenerate, parity stays clear
							state_q <= s_tlast ? ST_EMIT : ST_IDLE;
					end
				end
				ST_E_DIFF: state_q <= ST_E_LHS;
				ST_E_LHS:  state_q <= ST_E_RHS;
				ST_E_RHS:  state_q <= ST_E_CMP;
				ST_E_CMP: begin
					if (close_q) begin
						close_q <= 1'b0;
						state_q <= ST_E_DIFF;
					end else begin
						state_q <= done_q ? ST_EMIT : ST_IDLE;
					end
				end
				ST_DIV_GO: state_q <= ST_DIV_WAIT;
				ST_DIV_WAIT: begin
					if (sts.div_done)
						state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (sts.out_free) begin
						done_q  <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_comb begin
		cmd            = '0;
		cmd.accept     = accept;
		cmd.diff       = (state_q == ST_E_DIFF);
		cmd.mul_lhs    = (state_q == ST_E_LHS);
		cmd.mul_rhs    = (state_q == ST_E_RHS);
		cmd.cmp        = (state_q == ST_E_CMP);
		cmd.load_close = (state_q == ST_E_CMP) && close_q;
		cmd.div_start  = (state_q == ST_DIV_GO);
		cmd.emit       = (state_q == ST_EMIT) && sts.out_free;
		cmd.emit_kind  = kind_q;
	end

	`ASSERT_ALWAYS(a_emit_free, clk, arst_n, cmd.emit |-> sts.out_free, "emit into full output")
	`ASSERT_ALWAYS(a_close_due, clk, arst_n, close_q |-> done_q, "closing edge without result")
	`ASSERT_ALWAYS(a_div_runs, clk, arst_n, cmd.div_start |=> sts.div_busy, "divider did not start")
	`ASSERT_NEVER(a_edge_div, clk, arst_n, (state_q == ST_E_DIFF) && sts.div_busy,
		"edge test while divider busy")

endmodule

// ===== hw/rtl/centroid_point_in_polygon_test_unit.sv =====
// ---------------------------------------------------------------------------
// centroid_point_in_polygon_test_unit
// Polygon centroid and even-odd point-in-polygon test on a vertex stream.
// ---------------------------------------------------------------------------
// Usage: vertices enter on the s_ channel, tuser = opcode (0 subject,
// 1 boundary), tlast = last vertex of the polygon. A last subject vertex
// yields the centroid (m_tuser = 0); a last boundary vertex yields the
// verdict (m_tuser = 1, m_tdata[0] = inside) for the stored centroid.
// Steps per request, from acceptance until s_tready returns:
//   subject vertex, not last: none, it is taken directly in idle
//   boundary vertex, not first or last: one edge through the shared
//     multiplier (difference, two product passes, compare)
//   last boundary vertex: that edge, the closing edge, then the output load
//   last subject vertex: the bit-serial dividers work through the SUM_W-bit
//     sums (SUM_W = 31 + clog2(MAX_VERTICES+1)), then the output load
// Results sit in an output register; the next vertex is accepted while it
// waits. A new result that finds the register still full holds the
// controller until m_tready frees it. Reset clears the centroid, parity
// and polygon state; no request is lost or repeated under stalls.
// ---------------------------------------------------------------------------
module centroid_point_in_polygon_test_unit #(
	parameter int MAX_VERTICES = 4096
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [cpip_pkg::TDATA_W-1:0] s_tdata,   // vertex_x[30:0], vertex_y[61:31]
	input  logic                         s_tuser,   // opcode
	input  logic                         s_tlast,   // last_vertex
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [cpip_pkg::TDATA_W-1:0] m_tdata,   // inside_res[0], center_x[31:1], center_y[62:32]
	output logic                         m_tuser    // result_kind
);

	cpip_pkg::cmd_t cmd;
	cpip_pkg::sts_t sts;

	cpip_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	cpip_dp #(.MAX_VERTICES(MAX_VERTICES)) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule
